// ===== sv/tdcfh_pkg.sv =====
package tdcfh_pkg;

   localparam int NUM_CHIPS_DEFAULT   = 6;
   localparam int FINE_BINS_DEFAULT   = 512;
   localparam int COUNT_WIDTH_DEFAULT = 32;

   localparam int CHANNELS_PER_CHIP = 128;
   localparam int CHANNEL_WIDTH     = 10;
   localparam int FINE_WIDTH        = 9;
   localparam int BIN_COUNT_WIDTH   = 32;

   localparam logic [3:0] HIT_TYPE = 4'd1;

   typedef enum logic {
      OP_RECORD = 1'b0,
      OP_READ   = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type               opcode;
      logic [3:0]               record_type;
      logic [4:0]               fifo_number;
      logic [1:0]               pixel_number;
      logic [2:0]               column_number;
      logic [1:0]               tdc_number;
      logic [FINE_WIDTH-1:0]    fine_code;
      logic [CHANNEL_WIDTH-1:0] read_channel;
   } req_payload_type;

   typedef struct packed {
      logic [BIN_COUNT_WIDTH-1:0] bin_count;
      logic [CHANNEL_WIDTH-1:0]   bin_channel;
   } rsp_payload_type;

endpackage

// ===== sv/tdc_fine_code_histogram_unit.sv =====
// path: an accepted read is registered in the s1 stage, along with the ram read, and then in the rsp register
// throughput: one transaction per cycle, record or read, through a single
//   read-modify-write on the histogram ram with forwarding of the last write;
//   a read waiting behind a stalled rsp transaction holds req_stall high
// reset: the ram is swept to zero one bin per cycle over all NUM_CHIPS*128*FINE_BINS
//   bins (393216 at the defaults), with req_stall held high meanwhile
module tdc_fine_code_histogram_unit #(
   parameter int NUM_CHIPS   = tdcfh_pkg::NUM_CHIPS_DEFAULT,
   parameter int FINE_BINS   = tdcfh_pkg::FINE_BINS_DEFAULT,
   parameter int COUNT_WIDTH = tdcfh_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  tdcfh_pkg::req_payload_type req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output tdcfh_pkg::rsp_payload_type rsp_payload
);

   import tdcfh_pkg::*;

   localparam int NUM_CHANNELS = NUM_CHIPS * CHANNELS_PER_CHIP;
   localparam int DEPTH        = NUM_CHANNELS * FINE_BINS;
   localparam int AW           = $clog2(DEPTH);

   logic                       clearing_ff, clearing_in;
   logic [AW-1:0]              clear_addr_ff, clear_addr_in;

   logic                       s1_valid_ff, s1_valid_in;
   logic                       s1_read_ff, s1_read_in;
   logic                       s1_ok_ff, s1_ok_in;
   logic [AW-1:0]              s1_addr_ff, s1_addr_in;
   logic [CHANNEL_WIDTH-1:0]   s1_channel_ff, s1_channel_in;

   logic                       last_wr_valid_ff, last_wr_valid_in;
   logic [AW-1:0]              last_wr_addr_ff, last_wr_addr_in;
   logic [COUNT_WIDTH-1:0]     last_wr_data_ff, last_wr_data_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_payload_type            rsp_payload_ff, rsp_payload_in;

   logic                       accept;
   logic                       s1_hold;
   logic                       s1_adv;
   logic                       is_read;
   logic                       fine_ok;
   logic                       chip_ok;
   logic                       chan_ok;
   logic [CHANNEL_WIDTH-1:0]   hit_channel;
   logic [CHANNEL_WIDTH-1:0]   sel_channel;
   logic [AW-1:0]              req_addr;

   logic [COUNT_WIDTH-1:0]     rd_data;
   logic [COUNT_WIDTH-1:0]     cur_count;
   logic [COUNT_WIDTH-1:0]     next_count;
   logic [BIN_COUNT_WIDTH-1:0] cur_out;
   logic                       bin_wr;

   logic                       ram_wr_en;
   logic [AW-1:0]              ram_wr_addr;
   logic [COUNT_WIDTH-1:0]     ram_wr_data;

   // request decode and bin address
   assign is_read     = (req_payload.opcode == OP_READ);
   assign fine_ok     = {2'b00, req_payload.fine_code} < 11'(FINE_BINS);
   assign chip_ok     = {2'b00, req_payload.fifo_number[4:2]} < 5'(NUM_CHIPS);
   assign chan_ok     = {2'b00, req_payload.read_channel} < 12'(NUM_CHANNELS);
   assign hit_channel = {req_payload.fifo_number[4:2], req_payload.column_number,
                         req_payload.pixel_number, req_payload.tdc_number};
   assign sel_channel = is_read ? req_payload.read_channel : hit_channel;
   assign req_addr    = AW'(AW'(sel_channel) * AW'(FINE_BINS))
                        + AW'(req_payload.fine_code);

   // handshake
   assign s1_hold   = s1_valid_ff && s1_read_ff && rsp_valid_ff && rsp_stall;
   assign s1_adv    = !s1_hold;
   assign req_stall = clearing_ff || s1_hold;
   assign accept    = req_valid && !req_stall;

   // read-modify-write with forwarding of the write issued alongside the read
   assign cur_count  = (last_wr_valid_ff && (last_wr_addr_ff == s1_addr_ff))
                       ? last_wr_data_ff : rd_data;
   assign next_count = (&cur_count) ? cur_count : cur_count + COUNT_WIDTH'(1);
   assign bin_wr     = s1_valid_ff && !s1_read_ff && s1_ok_ff;

   generate
      if (COUNT_WIDTH > BIN_COUNT_WIDTH) begin : g_sat
         assign cur_out = (|cur_count[COUNT_WIDTH-1:BIN_COUNT_WIDTH])
                          ? {BIN_COUNT_WIDTH{1'b1}}
                          : cur_count[BIN_COUNT_WIDTH-1:0];
      end else begin : g_ext
         assign cur_out = BIN_COUNT_WIDTH'(cur_count);
      end
   endgenerate

   assign ram_wr_en   = clearing_ff || bin_wr;
   assign ram_wr_addr = clearing_ff ? clear_addr_ff : s1_addr_ff;
   assign ram_wr_data = clearing_ff ? '0 : next_count;

   always_comb begin
      clearing_in   = clearing_ff;
      clear_addr_in = clear_addr_ff;
      if (clearing_ff) begin
         clear_addr_in = clear_addr_ff + AW'(1);
         if (clear_addr_ff == AW'(DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end

      s1_valid_in   = s1_valid_ff;
      s1_read_in    = s1_read_ff;
      s1_ok_in      = s1_ok_ff;
      s1_addr_in    = s1_addr_ff;
      s1_channel_in = s1_channel_ff;
      if (s1_adv) begin
         s1_valid_in   = accept;
         s1_read_in    = is_read;
         s1_ok_in      = is_read ? (chan_ok && fine_ok)
                         : ((req_payload.record_type == HIT_TYPE) && chip_ok && fine_ok);
         s1_addr_in    = req_addr;
         s1_channel_in = req_payload.read_channel;
      end

      last_wr_valid_in = last_wr_valid_ff;
      last_wr_addr_in  = last_wr_addr_ff;
      last_wr_data_in  = last_wr_data_ff;
      if (s1_adv) begin
         last_wr_valid_in = bin_wr;
         last_wr_addr_in  = s1_addr_ff;
         last_wr_data_in  = next_count;
      end

      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (s1_valid_ff && s1_read_ff && s1_adv) begin
         rsp_valid_in             = 1'b1;
         rsp_payload_in.bin_count = s1_ok_ff ? cur_out : '0;
         rsp_payload_in.bin_channel = s1_channel_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff      <= 1'b1;
         clear_addr_ff    <= '0;
         s1_valid_ff      <= 1'b0;
         last_wr_valid_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         clearing_ff      <= clearing_in;
         clear_addr_ff    <= clear_addr_in;
         s1_valid_ff      <= s1_valid_in;
         last_wr_valid_ff <= last_wr_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_read_ff      <= s1_read_in;
      s1_ok_ff        <= s1_ok_in;
      s1_addr_ff      <= s1_addr_in;
      s1_channel_ff   <= s1_channel_in;
      last_wr_addr_ff <= last_wr_addr_in;
      last_wr_data_ff <= last_wr_data_in;
      rsp_payload_ff  <= rsp_payload_in;
   end

   tdcfh_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (DEPTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== sv/tdcfh_ram.sv =====
module tdcfh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/testbench.sv =====
module testbench;
   import tdcfh_pkg::*;

   localparam int NUM_CHANNELS = NUM_CHIPS_DEFAULT * CHANNELS_PER_CHIP;
   localparam int HOT_BINS     = 8;
   localparam int PHASE_ITEMS  = 410;

   typedef struct {
      req_payload_type txn;
      bit              known;
      logic [31:0]     count;
   } directed_row_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int mismatch_count = 0;

   logic [COUNT_WIDTH_DEFAULT-1:0] bin_tally [int];
   rsp_payload_type                bin_reads_pending [$];
   req_payload_type                hot_hits [HOT_BINS];
   directed_row_type               directed_rows [$];

   tdc_fine_code_histogram_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int flat_channel(input req_payload_type t);
      return int'(t.tdc_number) + 4 * int'(t.pixel_number) + 16 * int'(t.column_number)
         + CHANNELS_PER_CHIP * (int'(t.fifo_number) / 4);
   endfunction

   function automatic req_payload_type make_txn(input opcode_type op, input logic [3:0] rtype,
                                                input logic [4:0] fifo, input logic [1:0] pixel,
                                                input logic [2:0] column, input logic [1:0] tdc,
                                                input logic [8:0] fine, input logic [9:0] rchan);
      req_payload_type t;
      t.opcode        = op;
      t.record_type   = rtype;
      t.fifo_number   = fifo;
      t.pixel_number  = pixel;
      t.column_number = column;
      t.tdc_number    = tdc;
      t.fine_code     = fine;
      t.read_channel  = rchan;
      return t;
   endfunction

   // updates the tally on a hit, returns 1 with the bin contents on a read
   function automatic bit histogram_apply(input req_payload_type t, output rsp_payload_type r);
      int addr;
      r = '0;
      if (t.opcode == OP_RECORD) begin
         if (t.record_type == HIT_TYPE && int'(t.fifo_number) / 4 < NUM_CHIPS_DEFAULT
             && int'(t.fine_code) < FINE_BINS_DEFAULT) begin
            addr = flat_channel(t) * FINE_BINS_DEFAULT + int'(t.fine_code);
            if (!bin_tally.exists(addr)) bin_tally[addr] = '0;
            if (bin_tally[addr] != '1) begin
               bin_tally[addr] = bin_tally[addr] + COUNT_WIDTH_DEFAULT'(1);
            end
         end
         return 1'b0;
      end
      r.bin_channel = t.read_channel;
      addr = int'(t.read_channel) * FINE_BINS_DEFAULT + int'(t.fine_code);
      if (int'(t.read_channel) < NUM_CHANNELS && int'(t.fine_code) < FINE_BINS_DEFAULT
          && bin_tally.exists(addr)) begin
         r.bin_count = bin_tally[addr];
      end
      return 1'b1;
   endfunction

   function automatic req_payload_type random_txn();
      logic [63:0]     noise;
      int              pick;
      req_payload_type t;
      req_payload_type hot;
      noise = {$urandom(), $urandom()};
      t     = noise[$bits(req_payload_type)-1:0];
      pick  = $urandom_range(99);
      hot   = hot_hits[$urandom_range(HOT_BINS-1)];
      if (pick < 45) begin
         t.opcode        = OP_RECORD;
         t.record_type   = HIT_TYPE;
         t.fifo_number   = hot.fifo_number;
         t.pixel_number  = hot.pixel_number;
         t.column_number = hot.column_number;
         t.tdc_number    = hot.tdc_number;
         t.fine_code     = hot.fine_code;
      end else if (pick < 60) begin
         t.opcode      = OP_RECORD;
         t.record_type = HIT_TYPE;
      end else if (pick < 70) begin
         t.opcode = OP_RECORD;
      end else if (pick < 95) begin
         t.opcode       = OP_READ;
         t.read_channel = CHANNEL_WIDTH'(flat_channel(hot));
         t.fine_code    = hot.fine_code;
      end else begin
         t.opcode = OP_READ;
      end
      return t;
   endfunction

   task automatic send_txn(input req_payload_type t, input bit known, input logic [31:0] count);
      rsp_payload_type exp;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= t;
      do @(posedge clock); while (req_stall);
      if (histogram_apply(t, exp)) begin
         if (known) exp.bin_count = count;
         bin_reads_pending.push_back(exp);
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (bin_reads_pending.size() == 0) begin
            $error("rsp transaction with nothing pending");
            mismatch_count++;
         end else begin
            exp = bin_reads_pending.pop_front();
            if (rsp_payload.bin_count !== exp.bin_count) begin
               $error("bin_count: expected %0d, got %0d", exp.bin_count, rsp_payload.bin_count);
               mismatch_count++;
            end
            if (rsp_payload.bin_channel !== exp.bin_channel) begin
               $error("bin_channel: expected %0d, got %0d",
                      exp.bin_channel, rsp_payload.bin_channel);
               mismatch_count++;
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
   end

   initial begin
      #10_000_000;
      $display("** tdc_fine_code_histogram_unit: FAILED **");
      $finish;
   end

   initial begin
      // empty store, corners of the read address
      directed_rows.push_back('{make_txn(OP_READ, 4'd0, 5'd0, 2'd0, 3'd0, 2'd0, 9'd0, 10'd0),
                                1'b1, 32'd0});
      directed_rows.push_back('{make_txn(OP_READ, 4'd0, 5'd0, 2'd0, 3'd0, 2'd0, 9'd511, 10'd767),
                                1'b1, 32'd0});
      directed_rows.push_back('{make_txn(OP_READ, 4'd0, 5'd0, 2'd0, 3'd0, 2'd0, 9'd511, 10'd1023),
                                1'b1, 32'd0});
      directed_rows.push_back('{make_txn(OP_READ, 4'd0, 5'd0, 2'd0, 3'd0, 2'd0, 9'd0, 10'd768),
                                1'b1, 32'd0});
      // lowest and highest channel, back to back on one bin
      directed_rows.push_back('{make_txn(OP_RECORD, HIT_TYPE, 5'd0, 2'd0, 3'd0, 2'd0, 9'd0, 10'd0),
                                1'b0, 32'd0});
      directed_rows.push_back('{make_txn(OP_READ, 4'd0, 5'd0, 2'd0, 3'd0, 2'd0, 9'd0, 10'd0),
                                1'b1, 32'd1});
      directed_rows.push_back('{make_txn(OP_RECORD, HIT_TYPE, 5'd23, 2'd3, 3'd7, 2'd3, 9'd511,
                                         10'd0), 1'b0, 32'd0});
      directed_rows.push_back('{make_txn(OP_RECORD, HIT_TYPE, 5'd23, 2'd3, 3'd7, 2'd3, 9'd511,
                                         10'd0), 1'b0, 32'd0});
      directed_rows.push_back('{make_txn(OP_READ, 4'd0, 5'd0, 2'd0, 3'd0, 2'd0, 9'd511, 10'd767),
                                1'b1, 32'd2});
      // record types other than a hit
      directed_rows.push_back('{make_txn(OP_RECORD, 4'd0, 5'd0, 2'd0, 3'd0, 2'd0, 9'd0, 10'd0),
                                1'b0, 32'd0});
      directed_rows.push_back('{make_txn(OP_RECORD, 4'd15, 5'd0, 2'd0, 3'd0, 2'd0, 9'd0, 10'd0),
                                1'b0, 32'd0});
      directed_rows.push_back('{make_txn(OP_RECORD, 4'd2, 5'd0, 2'd0, 3'd0, 2'd0, 9'd0, 10'd0),
                                1'b0, 32'd0});
      directed_rows.push_back('{make_txn(OP_READ, 4'd0, 5'd0, 2'd0, 3'd0, 2'd0, 9'd0, 10'd0),
                                1'b0, 32'd0});
      // hits on chips beyond the store
      directed_rows.push_back('{make_txn(OP_RECORD, HIT_TYPE, 5'd24, 2'd0, 3'd0, 2'd0, 9'd0,
                                         10'd0), 1'b0, 32'd0});
      directed_rows.push_back('{make_txn(OP_RECORD, HIT_TYPE, 5'd31, 2'd3, 3'd7, 2'd3, 9'd511,
                                         10'd0), 1'b0, 32'd0});
      directed_rows.push_back('{make_txn(OP_READ, 4'd0, 5'd0, 2'd0, 3'd0, 2'd0, 9'd511, 10'd767),
                                1'b0, 32'd0});
      // mixed field patterns, record fields ignored on a read
      directed_rows.push_back('{make_txn(OP_RECORD, HIT_TYPE, 5'd3, 2'd1, 3'd2, 2'd2, 9'h155,
                                         10'd0), 1'b0, 32'd0});
      directed_rows.push_back('{make_txn(OP_RECORD, HIT_TYPE, 5'd21, 2'd2, 3'd5, 2'd1, 9'h0aa,
                                         10'h3ff), 1'b0, 32'd0});
      directed_rows.push_back('{make_txn(OP_READ, 4'd15, 5'd31, 2'd3, 3'd7, 2'd3, 9'h155, 10'd38),
                                1'b0, 32'd0});
      directed_rows.push_back('{make_txn(OP_READ, HIT_TYPE, 5'd0, 2'd0, 3'd0, 2'd0, 9'h0aa,
                                         10'd729), 1'b0, 32'd0});
      directed_rows.push_back('{make_txn(OP_READ, 4'd0, 5'd0, 2'd0, 3'd0, 2'd0, 9'd1, 10'd0),
                                1'b1, 32'd0});

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct   = (phase == 0) ? 23 : (phase == 1) ? 85 : 0;
         receiver_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 23 : 0;
         if (phase == 0) begin
            foreach (directed_rows[i])
               send_txn(directed_rows[i].txn, directed_rows[i].known, directed_rows[i].count);
         end
         for (int h = 0; h < HOT_BINS; h++) begin
            hot_hits[h] = make_txn(OP_RECORD, HIT_TYPE, 5'($urandom_range(23)),
                                   2'($urandom), 3'($urandom), 2'($urandom),
                                   9'($urandom), 10'd0);
         end
         repeat (PHASE_ITEMS) send_txn(random_txn(), 1'b0, 32'd0);
      end
      req_valid <= 1'b0;

      while (bin_reads_pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** tdc_fine_code_histogram_unit: PASSED **");
      end else begin
         $display("** tdc_fine_code_histogram_unit: FAILED **");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/tdcfh_pkg.sv
sv/tdcfh_ram.sv
sv/tdc_fine_code_histogram_unit.sv
tb/testbench.sv
